// File: rtl/bitmap_slot_allocator_defines.svh
// Assertion macros for the slot allocator RTL.
// Depends on nothing; files that assert include it by name.
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define BSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

// Checks that cons holds in the cycle after ante.
`define BSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot allocator check failed");

`endif

// File: rtl/bsa_pkg.sv
// Package for the bitmap slot allocator: beat types, operation codes and constants.
// Used by the allocator top and its engine; depends on nothing.
package bsa_pkg;

  localparam int MAX_SLOTS_DEF = 32;
  localparam int POS_W = 6;
  localparam int SLOT_W = 5;
  localparam int BYTES_W = 13;
  localparam int OFFSET_W = 17;
  localparam int PRODUCT_W = POS_W + BYTES_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
  localparam logic [POS_W-1:0] POOL_SLOTS_RESET = 6'd32;
  localparam logic [BYTES_W-1:0] SLOT_BYTES_RESET = 13'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SLOTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RELEASE_ALL = 2'd2,
    OP_ITERATE = 2'd3
  } op_t;

  typedef struct packed {
    op_t op;
    logic [SLOT_W-1:0] slot_index;
    logic [POS_W-1:0] cursor;
  } req_t;

  typedef struct packed {
    logic ok;
    logic [SLOT_W-1:0] granted_slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic [POS_W-1:0] next_cursor;
    logic [POS_W-1:0] in_use;
  } rsp_t;

endpackage

// File: rtl/bitmap_slot_allocator.sv
// Bitmap slot allocator: an accepted request beat is registered in req_q and its response in rsp.
// Throughput is one request per cycle while rsp_stall does not hold the output; the bitmap search
// and offset multiply are combinational between the request register and the response register.
// Reset (synchronous, active high) frees every slot, zeroes the count and restores
// pool_slots to 32 and slot_bytes to 1.
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  bsa_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output bsa_pkg::rsp_t                   rsp
);
  import bsa_pkg::*;

  logic [POS_W-1:0] pool_slots;
  logic [BYTES_W-1:0] slot_bytes;
  logic req_q_valid;
  req_t req_q;
  logic fire;
  rsp_t result;

  assign fire = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_slots <= POOL_SLOTS_RESET;
      slot_bytes <= SLOT_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_SLOTS: pool_slots <= cfg_data[POS_W-1:0];
        CFG_SLOT_BYTES: slot_bytes <= cfg_data[BYTES_W-1:0];
        default: pool_slots <= pool_slots;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      req_q <= req;
    end
  end

  bsa_engine #(.MAX_SLOTS(MAX_SLOTS)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (req_q),
    .pool_slots (pool_slots),
    .slot_bytes (slot_bytes),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule

// File: rtl/bsa_lsb.sv
// Lowest-set-bit encoder for the slot allocator bitmap searches.
// Depends on nothing beyond its parameter.
module bsa_lsb #(
  parameter int W = 32
) (
  input  logic [W-1:0]         vec,
  output logic                 found,
  output logic [$clog2(W)-1:0] idx
);

  localparam int IW = $clog2(W);

  always_comb begin
    found = |vec;
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

// File: rtl/bsa_engine.sv
// Slot allocator state (bitmap and count) and the combinational operation logic.
// Depends on bsa_pkg, bsa_lsb and bitmap_slot_allocator_defines.svh.
`include "bitmap_slot_allocator_defines.svh"

module bsa_engine #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  bsa_pkg::req_t                item,
  input  logic [bsa_pkg::POS_W-1:0]    pool_slots,
  input  logic [bsa_pkg::BYTES_W-1:0]  slot_bytes,
  output bsa_pkg::rsp_t                result
);
  import bsa_pkg::*;

  localparam int W = (MAX_SLOTS < 63) ? MAX_SLOTS : 63;
  localparam int IW = $clog2(W);
  localparam logic [POS_W-1:0] NMAX = POS_W'(W);

  logic [W-1:0] bitmap;
  logic [W-1:0] bitmap_next;
  logic [POS_W-1:0] count;
  logic [POS_W-1:0] count_next;

  logic [POS_W-1:0] n;
  logic [POS_W-1:0] sidx;
  logic [W-1:0] below_n;
  logic [W-1:0] above_cur;
  logic [W-1:0] rel_hit;
  logic [W-1:0] cur_hit;
  logic [W-1:0] free_vec;
  logic [W-1:0] taken_vec;
  logic [W-1:0] taken_rest;
  logic [W-1:0] after_vec;
  logic [W-1:0] grant_oh;

  logic alloc_found;
  logic first_found;
  logic second_found;
  logic after_found;
  logic [IW-1:0] alloc_idx;
  logic [IW-1:0] first_idx;
  logic [IW-1:0] second_idx;
  logic [IW-1:0] after_idx;

  logic ok;
  logic [POS_W-1:0] slot;
  logic [POS_W-1:0] nxt;
  logic [PRODUCT_W-1:0] product;
  logic [OFFSET_W-1:0] offset;

  assign n = (pool_slots > NMAX) ? NMAX : pool_slots;
  assign sidx = POS_W'(item.slot_index);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      below_n[i] = POS_W'(i) < n;
      above_cur[i] = POS_W'(i) > item.cursor;
      rel_hit[i] = POS_W'(i) == sidx;
      cur_hit[i] = POS_W'(i) == item.cursor;
    end
  end

  assign free_vec = ~bitmap & below_n;
  assign taken_vec = bitmap & below_n;
  assign taken_rest = taken_vec & (taken_vec - W'(1));
  assign after_vec = taken_vec & above_cur;
  assign grant_oh = free_vec & (~free_vec + W'(1));

  bsa_lsb #(.W(W)) u_alloc_lsb (.vec(free_vec), .found(alloc_found), .idx(alloc_idx));
  bsa_lsb #(.W(W)) u_first_lsb (.vec(taken_vec), .found(first_found), .idx(first_idx));
  bsa_lsb #(.W(W)) u_second_lsb (.vec(taken_rest), .found(second_found), .idx(second_idx));
  bsa_lsb #(.W(W)) u_after_lsb (.vec(after_vec), .found(after_found), .idx(after_idx));

  always_comb begin
    ok = 1'b0;
    slot = '0;
    nxt = '0;
    bitmap_next = bitmap;
    count_next = count;
    unique case (item.op)
      OP_ALLOC: begin
        if (alloc_found && (count < n)) begin
          ok = 1'b1;
          slot = POS_W'(alloc_idx);
          bitmap_next = bitmap | grant_oh;
          count_next = count + POS_W'(1);
        end
      end
      OP_RELEASE: begin
        if ((sidx < n) && (|(bitmap & rel_hit))) begin
          ok = 1'b1;
          bitmap_next = bitmap & ~rel_hit;
          if (count != '0) begin
            count_next = count - POS_W'(1);
          end
        end
      end
      OP_RELEASE_ALL: begin
        ok = 1'b1;
        bitmap_next = '0;
        count_next = '0;
      end
      OP_ITERATE: begin
        if (item.cursor == '0) begin
          if (first_found) begin
            ok = 1'b1;
            slot = POS_W'(first_idx);
            nxt = second_found ? POS_W'(second_idx) : n;
          end else begin
            nxt = n;
          end
        end else if (item.cursor >= n) begin
          nxt = n;
        end else begin
          ok = |(bitmap & cur_hit);
          slot = ok ? item.cursor : '0;
          nxt = after_found ? POS_W'(after_idx) : n;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign product = PRODUCT_W'(slot) * PRODUCT_W'(slot_bytes);
  assign offset = (product > PRODUCT_W'(OFFSET_MAX)) ? OFFSET_MAX : product[OFFSET_W-1:0];

  always_comb begin
    result.ok = ok;
    result.granted_slot = slot[SLOT_W-1:0];
    result.byte_offset = offset;
    result.next_cursor = nxt;
    result.in_use = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap <= '0;
      count <= '0;
    end else if (fire) begin
      bitmap <= bitmap_next;
      count <= count_next;
    end
  end

  `BSA_ASSERT_NOW(a_count_matches_bitmap, 1'b1, count == POS_W'($countones(bitmap)))
  `BSA_ASSERT_NEXT(a_release_all_clears, fire && (item.op == OP_RELEASE_ALL), (count == '0) && (bitmap == '0))
  `BSA_ASSERT_NEXT(a_alloc_counts_up, fire && (item.op == OP_ALLOC) && ok, count == $past(count) + POS_W'(1))

endmodule
